[src/mdc_pkg.sv]
// Shared types, codes and helper functions of the maze carver.
package mdc_pkg;

  // Item function codes.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Wall direction codes reported with a carved wall.
  localparam logic [1:0] DIR_COL_DEC = 2'd0;
  localparam logic [1:0] DIR_COL_INC = 2'd1;
  localparam logic [1:0] DIR_ROW_INC = 2'd2;
  localparam logic [1:0] DIR_ROW_DEC = 2'd3;

  // Field widths of the channels and registers.
  localparam int unsigned RandW  = 16;
  localparam int unsigned CoordW = 5;
  localparam int unsigned CountW = 6;

  // Configuration port.
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  // Register values handed to the walker.
  typedef struct packed {
    logic [CountW-1:0] row_count;
    logic [CountW-1:0] column_count;
  } mdc_cfg_t;

  // Remainder of a 16-bit value by three, from its base-four digit sum.
  function automatic logic [1:0] mod3(input logic [RandW-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < RandW / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

[src/mdc_if.sv]
// Valid/ready channel interfaces for the input items and the results.
interface mdc_in_if;
  import mdc_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [RandW-1:0]  random_value;
  modport source (output valid, func, random_value, input ready);
  modport sink   (input valid, func, random_value, output ready);
endinterface

interface mdc_res_if;
  import mdc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] from_row;
  logic [CoordW-1:0] from_col;
  logic [1:0]        wall_dir;
  logic              carved;
  logic              finished;
  modport source (output valid, from_row, from_col, wall_dir, carved, finished,
                  input ready);
  modport sink   (input valid, from_row, from_col, wall_dir, carved, finished,
                  output ready);
endinterface

[src/mdc_ram.sv]
// Simple dual-port synchronous RAM with a registered read port.
module mdc_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/mdc_cfg.sv]
// APB register file holding the grid row and column counts.
module mdc_cfg
  import mdc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  output logic [ApbDataW-1:0] prdata_o,
  output logic                pready_o,
  output mdc_cfg_t            cfg_o
);

  mdc_cfg_t cfg_q;
  logic     wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_count    <= CountW'(32);
      cfg_q.column_count <= CountW'(32);
    end else if (wr_en) begin
      unique case (paddr_i[2])
        REG_ROW_COUNT:    cfg_q.row_count    <= pwdata_i[CountW-1:0];
        REG_COLUMN_COUNT: cfg_q.column_count <= pwdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (paddr_i[2])
      REG_ROW_COUNT:    prdata_o = ApbDataW'(cfg_q.row_count);
      REG_COLUMN_COUNT: prdata_o = ApbDataW'(cfg_q.column_count);
      default:          prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[src/mdc_walker.sv]
// Sequencer that walks the maze with the visited map and cell stack in RAM.
module mdc_walker
  import mdc_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mdc_cfg_t cfg_i,
  mdc_in_if.sink   in_i,
  mdc_res_if.source res_o
);

  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned VDepth = 1 << AW;
  localparam int unsigned Grid  = MAX_ROWS * MAX_COLS;
  localparam int unsigned SAW   = $clog2(Grid);
  localparam int unsigned DW    = $clog2(Grid + 1);
  localparam int unsigned RNW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CNW   = $clog2(MAX_COLS + 1);
  localparam int unsigned RX    = (RW > CoordW) ? RW : CoordW;
  localparam int unsigned CX    = (CW > CoordW) ? CW : CoordW;

  typedef enum logic [2:0] {
    S_CLEAR, S_START, S_IDLE, S_TOP, S_CELL, S_NB, S_PICK, S_DONE
  } state_e;

  state_e          state_q;
  logic            start_pend_q;
  logic [AW-1:0]   clr_addr_q;
  logic [DW-1:0]   depth_q;
  logic [DW-1:0]   count_q;
  logic [RandW-1:0] rnd_q;
  logic [1:0]      rnd_mod3_q;
  logic [RW-1:0]   cur_r_q;
  logic [CW-1:0]   cur_c_q;
  logic [2:0]      nb_idx_q;
  logic [3:0]      free_q;
  logic [RW-1:0]   res_r_q;
  logic [CW-1:0]   res_c_q;
  logic [1:0]      res_dir_q;
  logic            res_carved_q;
  logic            out_vld_q;
  logic [CoordW-1:0] out_row_q;
  logic [CoordW-1:0] out_col_q;
  logic [1:0]      out_dir_q;
  logic            out_carved_q;
  logic            out_fin_q;

  logic [RNW-1:0]  rows;
  logic [CNW-1:0]  cols;
  logic [DW-1:0]   total;
  logic [RW:0]     nb_r [4];
  logic [CW:0]     nb_c [4];
  logic [1:0]      nb_dir [4];
  logic [3:0]      nb_ok;
  logic [2:0]      n_free;
  logic [1:0]      pick_k;
  logic [1:0]      pick_i;
  logic [1:0]      cap_i;
  logic [RX-1:0]   row_ext;
  logic [CX-1:0]   col_ext;

  logic            v_we, v_wdata, v_re, v_rdata;
  logic [AW-1:0]   v_waddr, v_raddr;
  logic            s_we, s_re;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [AW-1:0]   s_wdata, s_rdata;

  // Counts in use: a zero count is taken as one, and larger counts are clamped to the grid the memories hold.
  always_comb begin
    if (cfg_i.row_count == '0) begin
      rows = RNW'(1);
    end else if (32'(cfg_i.row_count) > MAX_ROWS) begin
      rows = RNW'(MAX_ROWS);
    end else begin
      rows = RNW'(cfg_i.row_count);
    end
    if (cfg_i.column_count == '0) begin
      cols = CNW'(1);
    end else if (32'(cfg_i.column_count) > MAX_COLS) begin
      cols = CNW'(MAX_COLS);
    end else begin
      cols = CNW'(cfg_i.column_count);
    end
  end

  assign total = DW'(32'(rows) * 32'(cols));

  // Neighbors of the current cell in the order row-1, col-1, row+1, col+1.
  always_comb begin
    nb_r[0]   = {1'b0, cur_r_q} - 1'b1;
    nb_c[0]   = {1'b0, cur_c_q};
    nb_dir[0] = DIR_ROW_DEC;
    nb_r[1]   = {1'b0, cur_r_q};
    nb_c[1]   = {1'b0, cur_c_q} - 1'b1;
    nb_dir[1] = DIR_COL_DEC;
    nb_r[2]   = {1'b0, cur_r_q} + 1'b1;
    nb_c[2]   = {1'b0, cur_c_q};
    nb_dir[2] = DIR_ROW_INC;
    nb_r[3]   = {1'b0, cur_r_q};
    nb_c[3]   = {1'b0, cur_c_q} + 1'b1;
    nb_dir[3] = DIR_COL_INC;
    nb_ok[0]  = (cur_r_q != '0) && (32'(nb_r[0]) < 32'(rows)) && (32'(nb_c[0]) < 32'(cols));
    nb_ok[1]  = (cur_c_q != '0) && (32'(nb_r[1]) < 32'(rows)) && (32'(nb_c[1]) < 32'(cols));
    nb_ok[2]  = (32'(nb_r[2]) < 32'(rows)) && (32'(nb_c[2]) < 32'(cols));
    nb_ok[3]  = (32'(nb_r[3]) < 32'(rows)) && (32'(nb_c[3]) < 32'(cols));
  end

  // Choice among the free neighbors.
  always_comb begin
    logic [1:0] seen;
    n_free = 3'($countones(free_q));
    unique case (n_free)
      3'd2:    pick_k = {1'b0, rnd_q[0]};
      3'd3:    pick_k = rnd_mod3_q;
      3'd4:    pick_k = rnd_q[1:0];
      default: pick_k = 2'd0;
    endcase
    pick_i = 2'd0;
    seen   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (free_q[i]) begin
        if (seen == pick_k) begin
          pick_i = 2'(i);
        end
        seen = seen + 2'd1;
      end
    end
  end

  assign cap_i = 2'(nb_idx_q - 3'd1);

  // Memory port control.
  always_comb begin
    v_we    = 1'b0;
    v_waddr = '0;
    v_wdata = 1'b0;
    v_re    = 1'b0;
    v_raddr = {nb_r[nb_idx_q[1:0]][RW-1:0], nb_c[nb_idx_q[1:0]][CW-1:0]};
    s_we    = 1'b0;
    s_waddr = depth_q[SAW-1:0];
    s_wdata = {nb_r[pick_i][RW-1:0], nb_c[pick_i][CW-1:0]};
    s_re    = 1'b0;
    s_raddr = SAW'(depth_q - DW'(1));
    unique case (state_q)
      S_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr_addr_q;
      end
      S_START: begin
        v_we    = 1'b1;
        v_wdata = 1'b1;
        s_we    = 1'b1;
        s_waddr = '0;
        s_wdata = '0;
      end
      S_TOP: s_re = 1'b1;
      S_NB:  v_re = ~nb_idx_q[2];
      S_PICK: begin
        if (n_free != 3'd0) begin
          v_we    = 1'b1;
          v_waddr = s_wdata;
          v_wdata = 1'b1;
          s_we    = (32'(depth_q) < Grid);
        end
      end
      default: ;
    endcase
  end

  mdc_ram #(.Width(1), .Depth(VDepth)) u_visited (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  mdc_ram #(.Width(AW), .Depth(Grid)) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // Sequencer state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      start_pend_q <= 1'b0;
      clr_addr_q   <= '0;
      depth_q      <= '0;
      count_q      <= '0;
      nb_idx_q     <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      // The output register empties on a transfer unless a new result loads it.
      if (out_vld_q && res_o.ready && state_q != S_DONE) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == '1) begin
            state_q <= start_pend_q ? S_START : S_IDLE;
          end
        end
        S_START: begin
          start_pend_q <= 1'b0;
          depth_q      <= DW'(1);
          count_q      <= DW'(1);
          state_q      <= S_DONE;
        end
        S_IDLE: begin
          if (in_i.valid) begin
            rnd_q        <= in_i.random_value;
            rnd_mod3_q   <= mod3(in_i.random_value);
            res_r_q      <= '0;
            res_c_q      <= '0;
            res_dir_q    <= '0;
            res_carved_q <= 1'b0;
            if (in_i.func == FUNC_START) begin
              start_pend_q <= 1'b1;
              clr_addr_q   <= '0;
              state_q      <= S_CLEAR;
            end else if (count_q >= total || depth_q == '0) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_TOP;
            end
          end
        end
        S_TOP: state_q <= S_CELL;
        S_CELL: begin
          cur_r_q  <= s_rdata[AW-1:CW];
          cur_c_q  <= s_rdata[CW-1:0];
          nb_idx_q <= '0;
          state_q  <= S_NB;
        end
        S_NB: begin
          if (nb_idx_q != '0) begin
            free_q[cap_i] <= nb_ok[cap_i] & ~v_rdata;
          end
          nb_idx_q <= nb_idx_q + 3'd1;
          if (nb_idx_q[2]) begin
            state_q <= S_PICK;
          end
        end
        S_PICK: begin
          if (n_free == 3'd0) begin
            // Dead end: back up one cell.
            depth_q <= depth_q - DW'(1);
            state_q <= (depth_q == DW'(1)) ? S_DONE : S_TOP;
          end else begin
            count_q <= count_q + DW'(1);
            if (32'(depth_q) < Grid) begin
              depth_q <= depth_q + DW'(1);
            end
            res_r_q      <= cur_r_q;
            res_c_q      <= cur_c_q;
            res_dir_q    <= nb_dir[pick_i];
            res_carved_q <= 1'b1;
            state_q      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_vld_q || res_o.ready) begin
            out_vld_q    <= 1'b1;
            out_row_q    <= row_ext[CoordW-1:0];
            out_col_q    <= col_ext[CoordW-1:0];
            out_dir_q    <= res_dir_q;
            out_carved_q <= res_carved_q;
            out_fin_q    <= (count_q >= total);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign row_ext = RX'(res_r_q);
  assign col_ext = CX'(res_c_q);

  assign in_i.ready     = (state_q == S_IDLE);
  assign res_o.valid    = out_vld_q;
  assign res_o.from_row = out_row_q;
  assign res_o.from_col = out_col_q;
  assign res_o.wall_dir = out_dir_q;
  assign res_o.carved   = out_carved_q;
  assign res_o.finished = out_fin_q;

endmodule

[src/maze_dfs_carver.sv]
// Top level of the randomized depth-first maze carver.
// The visited map and the cell stack each live in a one-port-read,
// one-port-write RAM, so every step is a short sequence of memory accesses:
// a step item that carves from the current stack top reads the stack and
// four visited-map entries and then writes both RAMs, and each dead-end
// cell popped while backtracking adds one stack read and four visited-map
// reads. A start item and reset both sweep the visited map, one entry per
// cycle, over all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (1024 at the
// default size); no item is accepted during that sweep. A finished result
// is held in an output register, so the next item is accepted while it waits.
module maze_dfs_carver
  import mdc_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  mdc_in_if.sink              in_i,
  mdc_res_if.source           res_o
);

  mdc_cfg_t cfg;

  // Configuration registers.
  mdc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // Maze walk sequencer.
  mdc_walker #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .res_o  (res_o)
  );

endmodule

[src/mdc_checker.sv]
// Port-level checks of the maze carver, bound to the top level.
module mdc_checker
  import mdc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [CoordW-1:0] from_row,
  input logic [CoordW-1:0] from_col,
  input logic [1:0]        wall_dir,
  input logic              carved
);

  // A pending result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result withdrawn before transfer");

  // A result without a carved wall reports zero coordinates and direction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !carved |-> from_row == '0 && from_col == '0 && wall_dir == '0)
    else $error("uncarved result has nonzero fields");

  // Items are worked one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

endmodule

bind maze_dfs_carver mdc_checker u_mdc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .from_row  (res_o.from_row),
  .from_col  (res_o.from_col),
  .wall_dir  (res_o.wall_dir),
  .carved    (res_o.carved)
);
